// File: src/ppi_pkg.sv
// Shared types and constants for the planar pose integrator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ppi_pkg;

	typedef enum logic [1:0] {
		KIND_VEL  = 2'd0,
		KIND_TELE = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	localparam logic [1:0] REG_TIME_STEP  = 2'd0;
	localparam logic [1:0] REG_FIELD_W    = 2'd1;
	localparam logic [1:0] REG_FIELD_H    = 2'd2;
	localparam logic [1:0] REG_CMD_TMO    = 2'd3;

	localparam logic [15:0] RST_TIME_STEP = 16'd1049;
	localparam logic [23:0] RST_FIELD_W   = 24'd726663;
	localparam logic [23:0] RST_FIELD_H   = 24'd726663;
	localparam logic [15:0] RST_CMD_TMO   = 16'd62;

	// angles in units of 2^-15 rad
	localparam int PI_Q         = 102944;
	localparam int TWO_PI_Q     = 205888;
	localparam int HALF_PI_Q    = 51472;
	localparam int QUARTER_PI_Q = 25736;
	localparam logic [31:0] ONE_Q30 = 32'd1073741824;

	// exact truncating division of 30-bit values: q = (v * M) >> K
	localparam int K_DIV6     = 33;
	localparam int K_DIV120   = 37;
	localparam int K_DIV5040  = 43;
	localparam int K_DIV24    = 35;
	localparam int K_DIV720   = 40;
	localparam int K_DIV40320 = 46;
	localparam logic [31:0] M_DIV6     = 32'(((64'd1 << K_DIV6) + 64'd5) / 64'd6);
	localparam logic [31:0] M_DIV120   = 32'(((64'd1 << K_DIV120) + 64'd119) / 64'd120);
	localparam logic [31:0] M_DIV5040  = 32'(((64'd1 << K_DIV5040) + 64'd5039) / 64'd5040);
	localparam logic [31:0] M_DIV24    = 32'(((64'd1 << K_DIV24) + 64'd23) / 64'd24);
	localparam logic [31:0] M_DIV720   = 32'(((64'd1 << K_DIV720) + 64'd719) / 64'd720);
	localparam logic [31:0] M_DIV40320 = 32'(((64'd1 << K_DIV40320) + 64'd40319) / 64'd40320);

	typedef struct packed {
		logic [15:0] time_step;
		logic [23:0] field_width;
		logic [23:0] field_height;
		logic [15:0] command_timeout;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [19:0] cmd_vel_x;
		logic signed [19:0] cmd_vel_y;
		logic signed [19:0] cmd_turn_rate;
		logic [23:0]        place_x;
		logic [23:0]        place_y;
		logic signed [18:0] place_heading;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef enum logic [5:0] {
		S_FETCH, S_AGE, S_TURN, S_HEAD, S_WRAP, S_FOLD,
		S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
		S_D3, S_D5, S_D7, S_D4, S_D6, S_D8, S_SC,
		S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7,
		S_V2, S_V3, S_SQ, S_OUT
	} state_t;

	// round half away from zero, then shift right
	function automatic logic signed [68:0] rnd_sh(input logic signed [68:0] v,
			input int unsigned sh);
		logic [68:0] mag;
		logic [68:0] r;
		mag = v[68] ? 69'(-v) : 69'(v);
		r = (mag + (69'd1 << (sh - 1))) >> sh;
		return v[68] ? -$signed(r) : $signed(r);
	endfunction

endpackage

// File: src/ppi_in_if.sv
// Request channel of the pose integrator: valid/ready plus item fields.
// No dependencies.
`timescale 1ns / 1ps

interface ppi_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [19:0] cmd_vel_x;
	logic signed [19:0] cmd_vel_y;
	logic signed [19:0] cmd_turn_rate;
	logic [23:0]        place_x;
	logic [23:0]        place_y;
	logic signed [18:0] place_heading;

	modport source (output valid, kind, cmd_vel_x, cmd_vel_y, cmd_turn_rate,
		place_x, place_y, place_heading, input ready);
	modport sink (input valid, kind, cmd_vel_x, cmd_vel_y, cmd_turn_rate,
		place_x, place_y, place_heading, output ready);
endinterface

// File: src/ppi_out_if.sv
// Result channel of the pose integrator: valid/ready plus pose fields.
// No dependencies.
`timescale 1ns / 1ps

interface ppi_out_if;
	logic               valid;
	logic               ready;
	logic [23:0]        pose_x;
	logic [23:0]        pose_y;
	logic [19:0]        speed;
	logic signed [19:0] turn_rate;
	logic               hit_wall;
	logic               pose_changed;

	modport source (output valid, pose_x, pose_y, speed, turn_rate, hit_wall,
		pose_changed, input ready);
	modport sink (input valid, pose_x, pose_y, speed, turn_rate, hit_wall,
		pose_changed, output ready);
endinterface

// File: src/ppi_cfg.sv
// APB-style register file: time step, field size, command timeout.
// Depends on ppi_pkg.
`timescale 1ns / 1ps

module ppi_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	output ppi_pkg::cfg_t  cfg
);
	import ppi_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step       <= RST_TIME_STEP;
			cfg_q.field_width     <= RST_FIELD_W;
			cfg_q.field_height    <= RST_FIELD_H;
			cfg_q.command_timeout <= RST_CMD_TMO;
		end else if (wr) begin
			case (paddr[3:2])
				REG_TIME_STEP: cfg_q.time_step       <= pwdata[15:0];
				REG_FIELD_W:   cfg_q.field_width     <= pwdata[23:0];
				REG_FIELD_H:   cfg_q.field_height    <= pwdata[23:0];
				REG_CMD_TMO:   cfg_q.command_timeout <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TIME_STEP: prdata = {16'd0, cfg_q.time_step};
			REG_FIELD_W:   prdata = {8'd0, cfg_q.field_width};
			REG_FIELD_H:   prdata = {8'd0, cfg_q.field_height};
			REG_CMD_TMO:   prdata = {16'd0, cfg_q.command_timeout};
			default:       prdata = 32'd0;
		endcase
	end
endmodule

// File: src/ppi_front.sv
// Front end: accepts requests, drops reserved kinds, queues the rest.
// Depends on ppi_pkg and ppi_in_if.
`timescale 1ns / 1ps

module ppi_front #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	ppi_in_if.sink         request,
	output ppi_pkg::head_t head,
	input  logic           pop
);
	import ppi_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           acc, push, known;
	item_t          in_item;

	assign known = request.kind == KIND_VEL || request.kind == KIND_TELE ||
		request.kind == KIND_TICK;
	assign request.ready = count_q != CW'(DEPTH);
	assign acc = request.valid && request.ready;
	assign push = acc && known;

	always_comb begin
		in_item.kind          = request.kind;
		in_item.cmd_vel_x     = request.cmd_vel_x;
		in_item.cmd_vel_y     = request.cmd_vel_y;
		in_item.cmd_turn_rate = request.cmd_turn_rate;
		in_item.place_x       = request.place_x;
		in_item.place_y       = request.place_y;
		in_item.place_heading = request.place_heading;
	end

	assign head.valid = count_q != '0;
	assign head.item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end
endmodule

// File: src/ppi_back.sv
// Back end: executes queued items; ticks run a sequencer around one shared
// multiplier (heading, sin/cos series, rotation, speed) and a sqrt loop.
// Depends on ppi_pkg and ppi_out_if.
`timescale 1ns / 1ps

module ppi_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ppi_pkg::cfg_t  cfg,
	input  ppi_pkg::head_t head,
	output logic           pop,
	ppi_out_if.source      result
);
	import ppi_pkg::*;

	localparam logic signed [17:0] PI_H = 18'(PI_Q);

	state_t state_q, state_d;

	logic [15:0]        age_q;
	logic signed [19:0] vx_q, vy_q, tr_q;
	logic [23:0]        pos_x_q, pos_y_q;
	logic signed [17:0] heading_q;
	logic               tele_q;

	logic signed [35:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [68:0] prod_q, acc_q;

	logic signed [24:0] h_q;
	logic               neg_q, cneg_q, swap_q;
	logic [29:0]        x_q, x2_q, p3_q, p4_q, p5_q, p6_q, p7_q, p8_q;
	logic [29:0]        q3_q, q5_q, q7_q, q4_q, q6_q;
	logic signed [31:0] s_q, c_q;
	logic signed [35:0] rr_q, ry_q;
	logic signed [25:0] dx_q;
	logic               wall_q, chg_q;
	logic [40:0]        sq_v_q, sq_r_q, sq_bit_q;
	logic [4:0]         sq_cnt_q;

	logic               res_valid_q, load;
	logic               sq_last;

	assign sq_last = sq_cnt_q == 5'd20;
	assign load = state_q == S_OUT && (!res_valid_q || result.ready);

	// next state
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			S_FETCH: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.item.kind == KIND_TICK) state_d = S_AGE;
				end
			end
			S_AGE:  state_d = S_TURN;
			S_TURN: state_d = S_HEAD;
			S_HEAD: state_d = S_WRAP;
			S_WRAP: begin
				if (h_q < 25'(PI_Q) && h_q >= -25'(PI_Q)) state_d = S_FOLD;
			end
			S_FOLD: state_d = S_P2;
			S_P2:   state_d = S_P3;
			S_P3:   state_d = S_P4;
			S_P4:   state_d = S_P5;
			S_P5:   state_d = S_P6;
			S_P6:   state_d = S_P7;
			S_P7:   state_d = S_P8;
			S_P8:   state_d = S_D3;
			S_D3:   state_d = S_D5;
			S_D5:   state_d = S_D7;
			S_D7:   state_d = S_D4;
			S_D4:   state_d = S_D6;
			S_D6:   state_d = S_D8;
			S_D8:   state_d = S_SC;
			S_SC:   state_d = S_R1;
			S_R1:   state_d = S_R2;
			S_R2:   state_d = S_R3;
			S_R3:   state_d = S_R4;
			S_R4:   state_d = S_R5;
			S_R5:   state_d = S_R6;
			S_R6:   state_d = S_R7;
			S_R7:   state_d = S_V2;
			S_V2:   state_d = S_V3;
			S_V3:   state_d = S_SQ;
			S_SQ: begin
				if (sq_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (load) state_d = S_FETCH;
			end
			default: state_d = S_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TURN: begin mul_a = 36'(tr_q); mul_b = $signed({17'd0, cfg.time_step}); end
			S_P2: begin mul_a = $signed({6'd0, x_q}); mul_b = $signed({3'd0, x_q}); end
			S_P3: begin mul_a = $signed({6'd0, prod_q[59:30]}); mul_b = $signed({3'd0, x_q}); end
			S_P4: begin mul_a = $signed({6'd0, x2_q}); mul_b = $signed({3'd0, x2_q}); end
			S_P5: begin mul_a = $signed({6'd0, prod_q[59:30]}); mul_b = $signed({3'd0, x_q}); end
			S_P6: begin mul_a = $signed({6'd0, p4_q}); mul_b = $signed({3'd0, x2_q}); end
			S_P7: begin mul_a = $signed({6'd0, prod_q[59:30]}); mul_b = $signed({3'd0, x_q}); end
			S_P8: begin mul_a = $signed({6'd0, p6_q}); mul_b = $signed({3'd0, x2_q}); end
			S_D3: begin mul_a = $signed({6'd0, p3_q}); mul_b = $signed({1'b0, M_DIV6}); end
			S_D5: begin mul_a = $signed({6'd0, p5_q}); mul_b = $signed({1'b0, M_DIV120}); end
			S_D7: begin mul_a = $signed({6'd0, p7_q}); mul_b = $signed({1'b0, M_DIV5040}); end
			S_D4: begin mul_a = $signed({6'd0, p4_q}); mul_b = $signed({1'b0, M_DIV24}); end
			S_D6: begin mul_a = $signed({6'd0, p6_q}); mul_b = $signed({1'b0, M_DIV720}); end
			S_D8: begin mul_a = $signed({6'd0, p8_q}); mul_b = $signed({1'b0, M_DIV40320}); end
			S_R1: begin mul_a = 36'(c_q); mul_b = 33'(vx_q); end
			S_R2: begin mul_a = 36'(s_q); mul_b = 33'(vy_q); end
			S_R3: begin mul_a = 36'(c_q); mul_b = 33'(vy_q); end
			S_R4: begin mul_a = 36'(s_q); mul_b = 33'(vx_q); end
			S_R5: begin mul_a = rr_q; mul_b = $signed({17'd0, cfg.time_step}); end
			S_R6: begin mul_a = ry_q; mul_b = $signed({17'd0, cfg.time_step}); end
			S_R7: begin mul_a = 36'(vx_q); mul_b = 33'(vx_q); end
			S_V2: begin mul_a = 36'(vy_q); mul_b = 33'(vy_q); end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 69'(mul_a * mul_b);
	end

	// fold helpers
	logic [17:0] fa0, fa1, fa2;
	logic        fcneg, fswap;
	always_comb begin
		fa0 = heading_q[17] ? 18'(-heading_q) : 18'(heading_q);
		fcneg = fa0 > 18'(HALF_PI_Q);
		fa1 = fcneg ? 18'(PI_Q) - fa0 : fa0;
		fswap = fa1 > 18'(QUARTER_PI_Q);
		fa2 = fswap ? 18'(HALF_PI_Q) - fa1 : fa1;
	end

	// sin/cos assembly
	logic signed [31:0] sn, cs, s_raw, c_raw;
	always_comb begin
		sn = $signed({2'd0, x_q}) - $signed({2'd0, q3_q}) + $signed({2'd0, q5_q})
			- $signed({2'd0, q7_q});
		cs = $signed(ONE_Q30) - $signed({3'd0, x2_q[29:1]}) + $signed({2'd0, q4_q})
			- $signed({2'd0, q6_q}) + $signed({2'd0, 30'(prod_q >>> K_DIV40320)});
		s_raw = swap_q ? cs : sn;
		c_raw = swap_q ? sn : cs;
	end

	// position update
	logic signed [25:0] dy;
	logic signed [26:0] nx, ny, fw, fh, cx, cy;
	logic               wall;
	always_comb begin
		dy = 26'(rnd_sh(prod_q, 26));
		nx = $signed({3'd0, pos_x_q}) + 27'(dx_q);
		ny = $signed({3'd0, pos_y_q}) - 27'(dy);
		fw = $signed({3'd0, cfg.field_width});
		fh = $signed({3'd0, cfg.field_height});
		wall = nx < 0 || nx > fw || ny < 0 || ny > fh;
		cx = (nx < 0) ? '0 : ((nx > fw) ? fw : nx);
		cy = (ny < 0) ? '0 : ((ny > fh) ? fh : ny);
	end

	logic [15:0]        age_n;
	logic signed [24:0] tp_y;
	logic [40:0]        sq_try;
	assign age_n = (age_q == 16'hFFFF) ? age_q : age_q + 16'd1;
	assign tp_y = $signed({1'b0, cfg.field_height}) - $signed({1'b0, head.item.place_y});
	assign sq_try = sq_r_q + sq_bit_q;

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
			vx_q <= '0;
			vy_q <= '0;
			tr_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			heading_q <= '0;
			tele_q <= 1'b0;
		end else begin
			case (state_q)
				S_FETCH: begin
					if (head.valid && head.item.kind == KIND_VEL) begin
						vx_q <= head.item.cmd_vel_x;
						vy_q <= head.item.cmd_vel_y;
						tr_q <= head.item.cmd_turn_rate;
						age_q <= '0;
					end else if (head.valid && head.item.kind == KIND_TELE) begin
						pos_x_q <= head.item.place_x;
						pos_y_q <= tp_y[24] ? '0 : tp_y[23:0];
						heading_q <= 18'(head.item.place_heading >>> 1);
						tele_q <= 1'b1;
					end
				end
				S_AGE: begin
					age_q <= age_n;
					if (age_n > cfg.command_timeout) begin
						vx_q <= '0;
						vy_q <= '0;
						tr_q <= '0;
					end
				end
				S_WRAP: begin
					if (h_q < 25'(PI_Q) && h_q >= -25'(PI_Q)) heading_q <= h_q[17:0];
				end
				S_R7: begin
					pos_x_q <= cx[23:0];
					pos_y_q <= cy[23:0];
					tele_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// tick datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_HEAD: h_q <= 25'(heading_q) + 25'(rnd_sh(prod_q, 13));
			S_WRAP: begin
				if (h_q >= 25'(PI_Q)) h_q <= h_q - 25'(TWO_PI_Q);
				else if (h_q < -25'(PI_Q)) h_q <= h_q + 25'(TWO_PI_Q);
			end
			S_FOLD: begin
				neg_q <= heading_q[17];
				cneg_q <= fcneg;
				swap_q <= fswap;
				x_q <= {fa2[14:0], 15'd0};
			end
			S_P3: x2_q <= prod_q[59:30];
			S_P4: p3_q <= prod_q[59:30];
			S_P5: p4_q <= prod_q[59:30];
			S_P6: p5_q <= prod_q[59:30];
			S_P7: p6_q <= prod_q[59:30];
			S_P8: p7_q <= prod_q[59:30];
			S_D3: p8_q <= prod_q[59:30];
			S_D5: q3_q <= 30'(prod_q >>> K_DIV6);
			S_D7: q5_q <= 30'(prod_q >>> K_DIV120);
			S_D4: q7_q <= 30'(prod_q >>> K_DIV5040);
			S_D6: q4_q <= 30'(prod_q >>> K_DIV24);
			S_D8: q6_q <= 30'(prod_q >>> K_DIV720);
			S_SC: begin
				s_q <= neg_q ? -s_raw : s_raw;
				c_q <= cneg_q ? -c_raw : c_raw;
			end
			S_R2: acc_q <= prod_q;
			S_R3: rr_q <= 36'(rnd_sh(acc_q - prod_q, 16));
			S_R4: acc_q <= prod_q;
			S_R5: ry_q <= 36'(rnd_sh(acc_q + prod_q, 16));
			S_R6: dx_q <= 26'(rnd_sh(prod_q, 26));
			S_R7: begin
				wall_q <= wall;
				chg_q <= tele_q || cx[23:0] != pos_x_q || cy[23:0] != pos_y_q;
			end
			S_V2: acc_q <= prod_q;
			S_V3: begin
				sq_v_q <= 41'(acc_q + prod_q);
				sq_r_q <= '0;
				sq_bit_q <= 41'd1 << 40;
				sq_cnt_q <= '0;
			end
			S_SQ: begin
				if (sq_v_q >= sq_try) begin
					sq_v_q <= sq_v_q - sq_try;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				sq_cnt_q <= sq_cnt_q + 5'd1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result.pose_x <= pos_x_q;
			result.pose_y <= cfg.field_height - pos_y_q;
			result.speed <= (sq_v_q > sq_r_q) ? 20'(sq_r_q + 41'd1) : 20'(sq_r_q);
			result.turn_rate <= tr_q;
			result.hit_wall <= wall_q;
			result.pose_changed <= chg_q;
		end
	end

	assign result.valid = res_valid_q;

	a_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FOLD |-> (heading_q >= -PI_H && heading_q < PI_H))
		else $error("heading not wrapped before fold");
	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ && sq_last) |=> state_q == S_OUT)
		else $error("sqrt loop overran");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (res_valid_q && state_q == S_FETCH))
		else $error("result not registered");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_FETCH && head.valid))
		else $error("pop outside fetch");
endmodule

// File: src/planar_pose_integrator.sv
// channel   | dir | handshake      | payload
// request   | in  | valid/ready    | kind, cmd_vel_x/y, cmd_turn_rate, place_x/y/heading
// result    | out | valid/ready    | pose_x, pose_y, speed, turn_rate, hit_wall, pose_changed
// config    | in  | APB write/read | time_step, field_width, field_height, command_timeout
//
// Velocity and teleport requests are executed in the fetch state. A tick runs
// the shared 36x33 multiplier sequence, repeating its 2*pi wrap step until the
// heading lies in [-pi, pi), and then the 21-step square-root loop.
// Reset is asynchronous, active low; no clearing pass. The request queue and
// the result register let each side stall independently.
// Depends on ppi_pkg, ppi_in_if, ppi_out_if, ppi_cfg, ppi_front, ppi_back.
`timescale 1ns / 1ps

module planar_pose_integrator #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	ppi_in_if.sink      request,
	ppi_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ppi_pkg::*;

	cfg_t  cfg;
	head_t head;
	logic  pop;

	ppi_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	ppi_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n, .request, .head, .pop
	);

	ppi_back u_back (
		.clk, .arst_n, .cfg, .head, .pop, .result
	);
endmodule

// File: dv/testbench.sv
// Self-checking bench for planar_pose_integrator: random and directed requests,
// a scoreboard that predicts every tick result, APB set-up between phases.
// Depends on ppi_pkg, ppi_in_if, ppi_out_if and the RTL under src.
`timescale 1ns / 1ps

module testbench;
	import ppi_pkg::*;

	typedef struct {
		logic [23:0]        x;
		logic [23:0]        y;
		logic [19:0]        speed;
		logic signed [19:0] turn;
		logic               wall;
		logic               changed;
	} pose_t;

	class pose_scoreboard;
		pose_t pose_q[$];
		int    errors;
		int    ticks;
		int    walls;
		int    requests;
		longint dt, fw, fh, tmo;
		longint px, py, hd, vx, vy, wz, age;
		bit    tele_pend;

		function void restart();
			dt = RST_TIME_STEP; fw = RST_FIELD_W; fh = RST_FIELD_H; tmo = RST_CMD_TMO;
			px = 0; py = 0; hd = 0; vx = 0; vy = 0; wz = 0; age = 0;
			tele_pend = 0;
		endfunction

		function longint round_shift(longint v, int sh);
			longint mag;
			longint r;
			mag = v < 0 ? -v : v;
			r = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
			return v < 0 ? -r : r;
		endfunction

		function longint wrap(longint h);
			longint t;
			longint q;
			t = h + PI_Q;
			q = t / TWO_PI_Q;
			if (t % TWO_PI_Q < 0)
				q--;
			return h - q * TWO_PI_Q;
		endfunction

		function void sine_cosine(longint h, output longint s, output longint c);
			bit neg, cneg, swap;
			longint unsigned a, x, x2, p3, p4, p5, p6, p7, p8, sn, cs, t;
			neg = h < 0; cneg = 0; swap = 0;
			a = neg ? -h : h;
			if (a > HALF_PI_Q) begin
				a = PI_Q - a;
				cneg = 1;
			end
			if (a > QUARTER_PI_Q) begin
				a = HALF_PI_Q - a;
				swap = 1;
			end
			x  = a * 32768;
			x2 = (x * x) >> 30;
			p3 = (x2 * x) >> 30;
			p4 = (x2 * x2) >> 30;
			p5 = (p4 * x) >> 30;
			p6 = (p4 * x2) >> 30;
			p7 = (p6 * x) >> 30;
			p8 = (p6 * x2) >> 30;
			sn = x - p3 / 6 + p5 / 120 - p7 / 5040;
			cs = 64'd1073741824 - x2 / 2 + p4 / 24 - p6 / 720 + p8 / 40320;
			if (swap) begin
				t = sn; sn = cs; cs = t;
			end
			s = neg ? -longint'(sn) : longint'(sn);
			c = cneg ? -longint'(cs) : longint'(cs);
		endfunction

		function longint unsigned speed_root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 40;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return v > r ? r + 1 : r;
		endfunction

		function void note_request(item_t it);
			longint s, c, rx, ry, nx, ny, t;
			pose_t e;
			bit wall;
			requests++;
			case (it.kind)
				KIND_VEL: begin
					vx = it.cmd_vel_x; vy = it.cmd_vel_y; wz = it.cmd_turn_rate;
					age = 0;
				end
				KIND_TELE: begin
					t = fh - longint'(it.place_y);
					py = t < 0 ? 0 : t;
					px = it.place_x;
					t = it.place_heading;
					hd = ((t + 262144) >>> 1) - 131072;
					tele_pend = 1;
				end
				KIND_TICK: begin
					if (age < 65535)
						age++;
					if (age > tmo) begin
						vx = 0; vy = 0; wz = 0;
					end
					hd = wrap(hd + round_shift(wz * dt, 13));
					sine_cosine(hd, s, c);
					rx = c * vx - s * vy;
					ry = c * vy + s * vx;
					nx = px + round_shift(round_shift(rx, 16) * dt, 26);
					ny = py - round_shift(round_shift(ry, 16) * dt, 26);
					wall = nx < 0 || nx > fw || ny < 0 || ny > fh;
					if (nx < 0) nx = 0;
					if (nx > fw) nx = fw;
					if (ny < 0) ny = 0;
					if (ny > fh) ny = fh;
					e.changed = tele_pend || nx != px || ny != py;
					tele_pend = 0;
					px = nx; py = ny;
					e.x = px[23:0];
					t = fh - py;
					e.y = t[23:0];
					e.speed = 20'(speed_root(longint'(vx * vx) + longint'(vy * vy)));
					e.turn = wz[19:0];
					e.wall = wall;
					ticks++;
					walls += wall;
					pose_q.insert(pose_q.size(), e);
				end
				default: ;
			endcase
		endfunction

		function void check_pose(pose_t got);
			pose_t e;
			if (pose_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d", $time, got.x, got.y);
				errors++;
				return;
			end
			e = pose_q.pop_front();
			if (got.x !== e.x) begin
				$display("%0t: pose_x expected %0d actual %0d", $time, e.x, got.x);
				errors++;
			end
			if (got.y !== e.y) begin
				$display("%0t: pose_y expected %0d actual %0d", $time, e.y, got.y);
				errors++;
			end
			if (got.speed !== e.speed) begin
				$display("%0t: speed expected %0d actual %0d", $time, e.speed, got.speed);
				errors++;
			end
			if (got.turn !== e.turn) begin
				$display("%0t: turn_rate expected %0d actual %0d", $time, e.turn, got.turn);
				errors++;
			end
			if (got.wall !== e.wall) begin
				$display("%0t: hit_wall expected %0b actual %0b", $time, e.wall, got.wall);
				errors++;
			end
			if (got.changed !== e.changed) begin
				$display("%0t: pose_changed expected %0b actual %0b", $time, e.changed,
					got.changed);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	bit          gaps_on;
	bit          hold_req;
	int          hold_left;

	ppi_in_if  req();
	ppi_out_if res();

	pose_scoreboard sb;

	planar_pose_integrator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_TIME_STEP: sb.dt  = val[15:0];
			REG_FIELD_W:   sb.fw  = val[23:0];
			REG_FIELD_H:   sb.fh  = val[23:0];
			REG_CMD_TMO:   sb.tmo = val[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [15:0] ts, logic [23:0] w, logic [23:0] h,
			logic [15:0] tmo);
		write_reg(REG_TIME_STEP, 32'(ts));
		write_reg(REG_FIELD_W, 32'(w));
		write_reg(REG_FIELD_H, 32'(h));
		write_reg(REG_CMD_TMO, 32'(tmo));
	endtask

	task automatic push_request(item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= it.kind;
		req.cmd_vel_x <= it.cmd_vel_x;
		req.cmd_vel_y <= it.cmd_vel_y;
		req.cmd_turn_rate <= it.cmd_turn_rate;
		req.place_x <= it.place_x;
		req.place_y <= it.place_y;
		req.place_heading <= it.place_heading;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_request(it);
	endtask

	// wait for every pending pose, then let a trailing tick drain
	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pose_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic item_t make_item(logic [1:0] k, int vx_, int vy_, int wz_,
			int x_, int y_, int h_);
		item_t it;
		it.kind = k;
		it.cmd_vel_x = 20'(vx_);
		it.cmd_vel_y = 20'(vy_);
		it.cmd_turn_rate = 20'(wz_);
		it.place_x = 24'(x_);
		it.place_y = 24'(y_);
		it.place_heading = 19'(h_);
		return it;
	endfunction

	function automatic logic [19:0] rand_vel();
		if ($urandom_range(0, 1))
			return 20'($urandom);
		return 20'($urandom_range(0, 8000) - 4000);
	endfunction

	function automatic item_t rand_item(logic [23:0] w, logic [23:0] h);
		item_t it;
		int p;
		it.cmd_vel_x = rand_vel();
		it.cmd_vel_y = rand_vel();
		it.cmd_turn_rate = rand_vel();
		it.place_heading = 19'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			it.place_x = 24'($urandom);
			it.place_y = 24'($urandom);
		end else begin
			it.place_x = 24'($urandom_range(0, w));
			it.place_y = 24'($urandom_range(0, h));
		end
		p = $urandom_range(0, 99);
		if (p < 64)
			it.kind = KIND_TICK;
		else if (p < 84)
			it.kind = KIND_VEL;
		else if (p < 95)
			it.kind = KIND_TELE;
		else
			it.kind = 2'd3;
		return it;
	endfunction

	task automatic random_run(int n, logic [23:0] w, logic [23:0] h, bit press);
		item_t it;
		int done;
		done = 0;
		while (done < n) begin
			it = rand_item(w, h);
			if (press && done == n / 2)
				hold_req = 1'b1;
			push_request(it);
			if (it.kind != 2'd3)
				done++;
		end
	endtask

	// result side: random stalls, long hold on request
	initial begin
		pose_t got;
		res.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				got.x = res.pose_x; got.y = res.pose_y; got.speed = res.speed;
				got.turn = res.turn_rate; got.wall = res.hit_wall;
				got.changed = res.pose_changed;
				sb.check_pose(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(0, 6);
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		sb = new();
		sb.restart();
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req.valid = 1'b0; req.kind = KIND_TICK;
		req.cmd_vel_x = '0; req.cmd_vel_y = '0; req.cmd_turn_rate = '0;
		req.place_x = '0; req.place_y = '0; req.place_heading = '0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset state, extremes, ignored kind, off-field teleports
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_VEL, 524287, 524287, 524287, 0, 0, 0));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_VEL, -524288, -524288, -524288, 0, 0, 0));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_TELE, 0, 0, 0, 16777215, 0, 262143));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_TELE, 0, 0, 0, 0, 16777215, -262144));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(2'd3, 1, 2, 3, 4, 5, 6));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_VEL, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_TELE, 0, 0, 0, 363331, 363331, 0));
		push_request(make_item(KIND_VEL, 4000, -2000, 3000, 0, 0, 0));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		push_request(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0));
		random_run(200, RST_FIELD_W, RST_FIELD_H, 1'b0);
		drain();

		configure(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
		random_run(260, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
		drain();

		configure(16'd0, 24'd0, 24'd0, 16'd0);
		random_run(120, 24'd0, 24'd0, 1'b0);
		drain();

		configure(16'd1, 24'd200000, 24'd90000, 16'd3);
		random_run(200, 24'd200000, 24'd90000, 1'b0);
		drain();

		configure(16'($urandom_range(1, 65535)), 24'd40000, 24'd700000,
			16'($urandom_range(0, 20)));
		random_run(260, 24'd40000, 24'd700000, 1'b0);
		drain();

		configure(RST_TIME_STEP, RST_FIELD_W, RST_FIELD_H, RST_CMD_TMO);
		gaps_on = 1'b0;
		random_run(260, RST_FIELD_W, RST_FIELD_H, 1'b0);
		drain();

		$display("Ran %0d requests over six register settings: %0d ticks checked, %0d wall hits.",
			sb.requests, sb.ticks, sb.walls);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/ppi_pkg.sv
src/ppi_in_if.sv
src/ppi_out_if.sv
src/ppi_cfg.sv
src/ppi_front.sv
src/ppi_back.sv
src/planar_pose_integrator.sv
dv/testbench.sv
